/* src/xte_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types and constants for the XML text escape encoder.
// ----------------------------------------------------------------------------
package xte_pkg;

    localparam int unsigned RUN_MAX     = 6;
    localparam int unsigned RUN_IW      = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One escaped run: bytes in order from index 0, length minus one.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_IW-1:0]       len_m1;
    } t_run;

endpackage : xte_pkg
`default_nettype wire

/* src/xte_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xte_front
// Accepts raw text bytes and classifies each into its escaped byte run, dropping carriage return in element mode.
// ----------------------------------------------------------------------------
module xte_front (
    input  wire logic        i_in_valid,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_in_stall,
    input  wire logic        i_attr_mode,
    input  wire logic        i_queue_full,
    output logic             o_push,
    output xte_pkg::t_run    o_run
);
    import xte_pkg::*;

    t_run       run;
    logic       drop;
    logic [1:0] tens;
    logic [3:0] units;

    always_comb begin
        case (i_in_byte[4:0]) inside
            [5'd30:5'd31]: tens = 2'd3;
            [5'd20:5'd29]: tens = 2'd2;
            [5'd10:5'd19]: tens = 2'd1;
            default:       tens = 2'd0;
        endcase
        case (tens)
            2'd3:    units = 4'(i_in_byte[4:0] - 5'd30);
            2'd2:    units = 4'(i_in_byte[4:0] - 5'd20);
            2'd1:    units = 4'(i_in_byte[4:0] - 5'd10);
            default: units = i_in_byte[3:0];
        endcase
    end

    always_comb begin
        run  = '0;
        drop = 1'b0;
        if (i_in_byte == CH_AMP) begin
            run.bytes[0] = CH_AMP;
            run.bytes[1] = 8'h61;
            run.bytes[2] = 8'h6D;
            run.bytes[3] = 8'h70;
            run.bytes[4] = CH_SEMI;
            run.len_m1   = 3'd4;
        end else if (i_in_byte == CH_LT) begin
            run.bytes[0] = CH_AMP;
            run.bytes[1] = 8'h6C;
            run.bytes[2] = 8'h74;
            run.bytes[3] = CH_SEMI;
            run.len_m1   = 3'd3;
        end else if (i_in_byte == CH_GT) begin
            run.bytes[0] = CH_AMP;
            run.bytes[1] = 8'h67;
            run.bytes[2] = 8'h74;
            run.bytes[3] = CH_SEMI;
            run.len_m1   = 3'd3;
        end else if (i_attr_mode && i_in_byte == CH_QUOT) begin
            run.bytes[0] = CH_AMP;
            run.bytes[1] = 8'h71;
            run.bytes[2] = 8'h75;
            run.bytes[3] = 8'h6F;
            run.bytes[4] = 8'h74;
            run.bytes[5] = CH_SEMI;
            run.len_m1   = 3'd5;
        end else if (!i_attr_mode && i_in_byte == CH_CR) begin
            drop = 1'b1;
        end else if (!i_attr_mode && i_in_byte == CH_LF) begin
            run.bytes[0] = i_in_byte;
            run.len_m1   = 3'd0;
        end else if (i_in_byte == CH_DEL) begin
            run.bytes[0] = CH_AMP;
            run.bytes[1] = CH_HASH;
            run.bytes[2] = 8'h31;
            run.bytes[3] = 8'h32;
            run.bytes[4] = 8'h37;
            run.bytes[5] = CH_SEMI;
            run.len_m1   = 3'd5;
        end else if (i_in_byte < CH_SPACE) begin
            run.bytes[0] = CH_AMP;
            run.bytes[1] = CH_HASH;
            if (tens == 2'd0) begin
                run.bytes[2] = {4'h3, units};
                run.bytes[3] = CH_SEMI;
                run.len_m1   = 3'd3;
            end else begin
                run.bytes[2] = {6'b001100, tens};
                run.bytes[3] = {4'h3, units};
                run.bytes[4] = CH_SEMI;
                run.len_m1   = 3'd4;
            end
        end else begin
            run.bytes[0] = i_in_byte;
            run.len_m1   = 3'd0;
        end
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full && !drop;
    assign o_run      = run;

endmodule : xte_front
`default_nettype wire

/* src/xte_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xte_queue
// Short first-in first-out queue of escaped runs between front and back.
// ----------------------------------------------------------------------------
module xte_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire xte_pkg::t_run i_run,
    output logic               o_full,
    output logic               o_empty,
    input  wire logic          i_pop,
    output xte_pkg::t_run      o_head
);
    import xte_pkg::*;

    t_run                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule : xte_queue
`default_nettype wire

/* src/xte_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xte_back
// Serialises queued runs into output bytes, one per cycle while the output is not stalled, marking the last.
// ----------------------------------------------------------------------------
module xte_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire xte_pkg::t_run i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last_of_run,
    input  wire logic          i_out_stall
);
    import xte_pkg::*;

    logic [RUN_IW-1:0] r_idx, n_idx;
    logic              r_valid, n_valid;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic              load;
    logic              is_last;

    assign load    = !r_valid || !i_out_stall;
    assign is_last = (r_idx == i_head.len_m1);

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_byte = i_head.bytes[r_idx];
                n_last = is_last;
                if (is_last) begin
                    n_idx = '0;
                    o_pop = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

endmodule : xte_back
`default_nettype wire

/* src/xml_text_escape_encoder_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xml_text_escape_encoder_top
// XML text escaper: one input byte becomes a run of one to six output bytes, or none for a dropped carriage return.
// Path from input accept to first output byte: run queue, then output register.
// Throughput: one input item per cycle for plain bytes while the queue is not
// full and the output is not stalled; the serialiser sends a longer run one byte at a time.
// Four-entry run queue decouples input from output.
// Reset: synchronous, active low; clears queue, serialiser and attribute mode.
// ----------------------------------------------------------------------------
module xml_text_escape_encoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_in_byte,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    input  wire logic       i_out_stall,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_attribute_mode,
    output logic            o_cfg_ready
);
    import xte_pkg::*;

    logic r_attribute_mode;
    logic push, pop, full, empty;
    t_run run_in, run_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attribute_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_attribute_mode <= i_cfg_attribute_mode;
        end
    end

    xte_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .o_in_stall   (o_in_stall),
        .i_attr_mode  (r_attribute_mode),
        .i_queue_full (full),
        .o_push       (push),
        .o_run        (run_in)
    );

    xte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run_in),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (run_head)
    );

    xte_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (run_head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .i_out_stall   (i_out_stall)
    );

endmodule : xml_text_escape_encoder_top
`default_nettype wire

/* tb/tb_xml_text_escape_encoder_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xml_text_escape_encoder_top
// Self-checking bench for the XML text escape encoder. A directed table covers
// the entity bytes, control bytes, newline, carriage return, quote and high
// bytes in both escape modes, then randomised text runs in alternating modes.
// Every output byte and its end-of-run flag is checked in order against the
// table text or an escaping model kept in the bench, under random gaps on both
// sides, one long output hold and full drains before each mode change.
// ----------------------------------------------------------------------------
module tb_xml_text_escape_encoder_top;
    import xte_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 52;
    localparam int NUM_PHASES     = 4;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_esc_byte;

    typedef struct {
        bit    typed;
        string txt;
    } t_offer;

    typedef struct {
        bit         mode;
        logic [7:0] ch;
        bit         typed;
        string      txt;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic [7:0] i_in_byte;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid;
    logic       i_cfg_attribute_mode;
    logic       o_cfg_ready;

    t_esc_byte  escaped_q[$];
    t_offer     offer_q[$];
    logic       attr_mode = 1'b0;
    int         err_cnt   = 0;
    int         in_cnt    = 0;
    int         out_cnt   = 0;
    int         cfg_cnt   = 0;
    int         quiet_cnt = 0;
    int         hold_left = 0;
    bit         idle_on   = 1'b1;
    bit         hold_req  = 1'b0;
    bit         hold_done = 1'b0;

    // mode 0 rows first: reset leaves element mode in force
    t_row dir_tab [24] = '{
        '{1'b0, CH_AMP,   1'b1, "&amp;"},
        '{1'b0, CH_LT,    1'b1, "&lt;"},
        '{1'b0, CH_GT,    1'b1, "&gt;"},
        '{1'b0, CH_QUOT,  1'b1, "\""},
        '{1'b0, CH_CR,    1'b1, ""},
        '{1'b0, CH_LF,    1'b1, "\n"},
        '{1'b0, 8'h00,    1'b1, "&#0;"},
        '{1'b0, 8'h09,    1'b1, "&#9;"},
        '{1'b0, 8'h1F,    1'b1, "&#31;"},
        '{1'b0, CH_DEL,   1'b1, "&#127;"},
        '{1'b0, CH_SPACE, 1'b1, " "},
        '{1'b0, 8'h41,    1'b0, ""},
        '{1'b0, 8'h80,    1'b0, ""},
        '{1'b0, 8'hFF,    1'b0, ""},
        '{1'b0, 8'h7E,    1'b0, ""},
        '{1'b1, CH_QUOT,  1'b1, "&quot;"},
        '{1'b1, CH_CR,    1'b1, "&#13;"},
        '{1'b1, CH_LF,    1'b1, "&#10;"},
        '{1'b1, 8'h00,    1'b1, "&#0;"},
        '{1'b1, CH_AMP,   1'b1, "&amp;"},
        '{1'b1, CH_DEL,   1'b1, "&#127;"},
        '{1'b1, 8'hFF,    1'b0, ""},
        '{1'b1, 8'h55,    1'b0, ""},
        '{1'b1, 8'hAA,    1'b0, ""}
    };

    always #5 i_clk = ~i_clk;

    xml_text_escape_encoder_top u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_byte            (i_in_byte),
        .o_in_stall           (o_in_stall),
        .o_out_valid          (o_out_valid),
        .o_out_byte           (o_out_byte),
        .o_last_of_run        (o_last_of_run),
        .i_out_stall          (i_out_stall),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_attribute_mode (i_cfg_attribute_mode),
        .o_cfg_ready          (o_cfg_ready)
    );

    function automatic void push_text(string t);
        for (int i = 0; i < t.len(); i++) begin
            escaped_q.push_back('{t[i], (i == t.len() - 1)});
        end
    endfunction

    function automatic void escape_byte(logic [7:0] b, logic attr);
        if (b == CH_AMP) begin
            push_text("&amp;");
        end else if (b == CH_LT) begin
            push_text("&lt;");
        end else if (b == CH_GT) begin
            push_text("&gt;");
        end else if (attr && b == CH_QUOT) begin
            push_text("&quot;");
        end else if (!attr && b == CH_CR) begin
            // dropped in element text
        end else if (!attr && b == CH_LF) begin
            escaped_q.push_back('{b, 1'b1});
        end else if (b < CH_SPACE || b == CH_DEL) begin
            push_text($sformatf("&#%0d;", b));
        end else begin
            escaped_q.push_back('{b, 1'b1});
        end
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_offer    o;
        t_esc_byte e;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                attr_mode = i_cfg_attribute_mode;
                cfg_cnt++;
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                o = offer_q.pop_front();
                if (o.typed) begin
                    push_text(o.txt);
                end else begin
                    escape_byte(i_in_byte, attr_mode);
                end
                in_cnt++;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                out_cnt++;
                moved = 1'b1;
                if (escaped_q.size() == 0) begin
                    note_error($sformatf("unexpected byte %02h last %0b",
                                         o_out_byte, o_last_of_run));
                end else begin
                    e = escaped_q.pop_front();
                    if (o_out_byte !== e.ch || o_last_of_run !== e.last) begin
                        note_error($sformatf("expected %02h last %0b, got %02h last %0b",
                                             e.ch, e.last, o_out_byte, o_last_of_run));
                    end
                end
            end
            quiet_cnt = moved ? 0 : quiet_cnt + 1;
            if (quiet_cnt >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", quiet_cnt);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // output side: random stalls plus one long hold on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(0, 99) < 7);
        end
    end

    task automatic send_item(input logic [7:0] b, input bit typed, input string txt);
        while (idle_on && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        offer_q.push_back('{typed, txt});
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (escaped_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        drain_outputs();
        // a dropped carriage return may still be in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_attribute_mode <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] b;
        logic [7:0] specials [8];
        int         cnt;
        int         r;
        bit         hold_sent;
        bit         pause_sent;
        specials = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_CR, CH_LF, 8'h00, CH_DEL};
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_in_byte            = 8'h00;
        i_cfg_valid          = 1'b0;
        i_cfg_attribute_mode = 1'b0;
        hold_sent            = 1'b0;
        pause_sent           = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != attr_mode) begin
                set_mode(dir_tab[i].mode);
            end
            send_item(dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].txt);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_mode(1'(ph % 2));
            idle_on = (ph != 2);
            cnt = 0;
            while (cnt < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    b = specials[3'($urandom_range(0, 7))];
                end else if (r < 55) begin
                    b = 8'($urandom_range(0, 31));
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                send_item(b, 1'b0, "");
                if (!(attr_mode == 1'b0 && b == CH_CR)) begin
                    cnt++;
                end
                if (ph == 1 && cnt == 10 && !hold_sent) begin
                    hold_req  = 1'b1;
                    hold_sent = 1'b1;
                end
                if (ph == 3 && cnt == 20 && !pause_sent) begin
                    drain_outputs();
                    pause_sent = 1'b1;
                end
            end
        end
        idle_on = 1'b1;

        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("covered %0d text bytes in element and attribute mode, %0d mode writes,",
                 in_cnt, cfg_cnt);
        $display("%0d escaped bytes out, one long output hold, %0d mismatches",
                 out_cnt, err_cnt);
        if (err_cnt == 0 && escaped_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/xte_pkg.sv
src/xte_front.sv
src/xte_queue.sv
src/xte_back.sv
src/xml_text_escape_encoder_top.sv
tb/tb_xml_text_escape_encoder_top.sv
